FILE: hw/rtl/smap_pkg.sv
// Shared types and constants for the STUN mapped-address parser.
// No dependencies; imported by the parser, its checker and the testbench.
package smap_pkg;

  localparam int MAX_BYTES = 1024;
  localparam int OFF_W     = $clog2(MAX_BYTES + 1);

  localparam logic [OFF_W-1:0] OFF_LIMIT    = OFF_W'(MAX_BYTES);
  localparam logic [OFF_W-1:0] OFF_HDR_LAST = OFF_W'(19);
  localparam logic [OFF_W-1:0] OFF_MIN_HDR  = OFF_W'(2);

  localparam logic [7:0]  HDR_BYTE     = 8'h01;
  localparam logic [15:0] ATTR_MAPPED  = 16'h0020;
  localparam logic [15:0] MIN_MAP_LEN  = 16'd8;
  localparam logic [7:0]  XOR_B0       = 8'h21;
  localparam logic [7:0]  XOR_B1       = 8'h12;
  localparam logic [7:0]  XOR_B2       = 8'hA4;
  localparam logic [7:0]  XOR_B3       = 8'h42;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_ATTR_HDR = 2'd1,
    PH_ATTR_VAL = 2'd2,
    PH_DONE     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STS_FOUND       = 2'd0,
    STS_NOT_BINDING = 2'd1,
    STS_NO_ATTR     = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } smap_in_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] mapped_ip;
    logic [15:0] mapped_port;
  } smap_out_t;

endpackage

FILE: hw/rtl/stun_mapped_address_parser.sv
// The result appears in out_data in the cycle after the final byte is accepted.
// Throughput: one byte per cycle while not stalled; bytes past MAX_BYTES are not parsed.
// in_stall rises only while a finished result sits in the output register and is stalled.
// Reset (rst_n low, synchronous) returns the parser to the header phase and drops out_valid.
// Top level: byte-serial STUN binding-response parser, XOR-MAPPED-ADDRESS extraction.
// Depends on smap_pkg.
module stun_mapped_address_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  smap_pkg::smap_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output smap_pkg::smap_out_t out_data
);
  import smap_pkg::*;

  logic [OFF_W-1:0] off_r,    off_nxt;
  phase_t           phase_r,  phase_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [15:0]      kind_r,   kind_nxt;
  logic [15:0]      rem_r,    rem_nxt;
  logic [2:0]       pos_r,    pos_nxt;
  logic             found_r,  found_nxt;
  logic [15:0]      port_r,   port_nxt;
  logic [31:0]      ip_r,     ip_nxt;

  logic             out_valid_r;
  smap_out_t        out_data_r, result;

  logic             accept, take, close;
  logic [7:0]       b;
  logic [15:0]      len;
  logic [16:0]      padded;
  logic [15:0]      rem_pad;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign take      = accept & (off_r != OFF_LIMIT);
  assign close     = accept & in_data.end_of_packet;
  assign b         = in_data.data_byte;
  assign len       = {rem_r[15:8], b};
  assign padded    = ({1'b0, len} + 17'd3) & ~17'd3;
  assign rem_pad   = padded[16] ? 16'hFFFF : padded[15:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    off_nxt    = off_r;
    phase_nxt  = phase_r;
    hdr_ok_nxt = hdr_ok_r;
    kind_nxt   = kind_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    port_nxt   = port_r;
    ip_nxt     = ip_r;
    if (take) begin
      off_nxt = off_r + 1'b1;
      case (phase_r)
        PH_HEADER: begin
          if ((off_r == '0 || off_r == OFF_W'(1)) && b != HDR_BYTE) begin
            hdr_ok_nxt = 1'b0;
            phase_nxt  = PH_DONE;
          end else if (off_r >= OFF_HDR_LAST) begin
            phase_nxt = PH_ATTR_HDR;
            pos_nxt   = '0;
          end
        end
        PH_ATTR_HDR: begin
          case (pos_r)
            3'd0:    kind_nxt = {b, 8'h00};
            3'd1:    kind_nxt = {kind_r[15:8], b};
            3'd2:    rem_nxt  = {b, 8'h00};
            default: begin
              if (kind_r == ATTR_MAPPED && len < MIN_MAP_LEN) begin
                kind_nxt = '0;
              end
              rem_nxt = rem_pad;
            end
          endcase
          if (pos_r == 3'd3) begin
            pos_nxt   = '0;
            phase_nxt = (rem_pad == '0) ? PH_ATTR_HDR : PH_ATTR_VAL;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
        PH_ATTR_VAL: begin
          if (kind_r == ATTR_MAPPED && pos_r == 3'd7) begin
            ip_nxt[7:0] = b ^ XOR_B3;
            found_nxt   = 1'b1;
            phase_nxt   = PH_DONE;
          end else begin
            if (kind_r == ATTR_MAPPED) begin
              case (pos_r)
                3'd2:    port_nxt[15:8] = b ^ XOR_B0;
                3'd3:    port_nxt[7:0]  = b ^ XOR_B1;
                3'd4:    ip_nxt[31:24]  = b ^ XOR_B0;
                3'd5:    ip_nxt[23:16]  = b ^ XOR_B1;
                3'd6:    ip_nxt[15:8]   = b ^ XOR_B2;
                default: ;
              endcase
            end
            pos_nxt = pos_r + 1'b1;
            rem_nxt = rem_r - 1'b1;
            if (rem_r == 16'd1) begin
              pos_nxt   = '0;
              phase_nxt = PH_ATTR_HDR;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.status      = STS_NO_ATTR;
    result.mapped_ip   = '0;
    result.mapped_port = '0;
    if (!hdr_ok_nxt || off_nxt < OFF_MIN_HDR) begin
      result.status = STS_NOT_BINDING;
    end else if (found_nxt) begin
      result.status      = STS_FOUND;
      result.mapped_ip   = ip_nxt;
      result.mapped_port = port_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || close) begin
      off_r    <= '0;
      phase_r  <= PH_HEADER;
      hdr_ok_r <= 1'b1;
      kind_r   <= '0;
      rem_r    <= '0;
      pos_r    <= '0;
      found_r  <= 1'b0;
    end else begin
      off_r    <= off_nxt;
      phase_r  <= phase_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      kind_r   <= kind_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    port_r <= port_nxt;
    ip_r   <= ip_nxt;
    if (close) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (close) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/smap_checker.sv
// Port-level checks for the STUN mapped-address parser, bound to its top level.
// Depends on smap_pkg and stun_mapped_address_parser.
module smap_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input smap_pkg::smap_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input smap_pkg::smap_out_t out_data
);
  import smap_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.end_of_packet |=> out_valid)
    else $error("final byte of request gave no result");

  a_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STS_FOUND
      |-> out_data.mapped_ip == '0 && out_data.mapped_port == '0)
    else $error("address or port set without a found status");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule

bind stun_mapped_address_parser smap_checker u_smap_checker (.*);

FILE: tb/stun_mapped_address_parser_test.sv
// Self-checking testbench for stun_mapped_address_parser: byte-serial datagrams in,
// one status/address report per datagram out, checked against an in-bench parser.
// Depends on smap_pkg and the parser RTL.
module stun_mapped_address_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import smap_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  bit        clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  smap_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  smap_out_t out_data;

  stun_mapped_address_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  smap_out_t  pending_reports[$];
  logic [7:0] datagram[$];
  int         src_idle_pct;
  int         snk_stall_pct;
  int         bytes_sent;
  int         reports_made;
  int         mismatches;
  int         cycle_count;

  logic [OFF_W-1:0] pos_q;
  phase_t           phase_q;
  logic             hdr_good;
  logic [15:0]      kind_q;
  logic [15:0]      left_q;
  logic [15:0]      vpos_q;
  logic             found_q;
  logic [15:0]      port_q;
  logic [31:0]      ip_q;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void clear_parser();
    pos_q    = '0;
    phase_q  = PH_HEADER;
    hdr_good = 1'b1;
    kind_q   = '0;
    left_q   = '0;
    vpos_q   = '0;
    found_q  = 1'b0;
    port_q   = '0;
    ip_q     = '0;
  endfunction

  task automatic parse_stun_byte(input logic [7:0] b);
    logic [15:0] len;
    logic [16:0] padded;
    case (phase_q)
      PH_HEADER: begin
        if ((pos_q == 0 || pos_q == 1) && b != HDR_BYTE) begin
          hdr_good = 1'b0;
          phase_q  = PH_DONE;
        end else if (pos_q >= OFF_HDR_LAST) begin
          phase_q = PH_ATTR_HDR;
          vpos_q  = '0;
        end
      end
      PH_ATTR_HDR: begin
        case (vpos_q)
          16'd0: kind_q = {b, 8'h00};
          16'd1: kind_q = {kind_q[15:8], b};
          16'd2: left_q = {b, 8'h00};
          default: begin
            len    = {left_q[15:8], b};
            padded = ({1'b0, len} + 17'd3) & 17'h1FFFC;
            if (kind_q == ATTR_MAPPED && len < MIN_MAP_LEN) kind_q = '0;
            left_q = padded[16] ? 16'hFFFF : padded[15:0];
          end
        endcase
        vpos_q = vpos_q + 16'd1;
        if (vpos_q >= 16'd4) begin
          vpos_q  = '0;
          phase_q = (left_q == 0) ? PH_ATTR_HDR : PH_ATTR_VAL;
        end
      end
      PH_ATTR_VAL: begin
        if (kind_q == ATTR_MAPPED) begin
          case (vpos_q)
            16'd2: port_q = {b ^ XOR_B0, 8'h00};
            16'd3: port_q = {port_q[15:8], b ^ XOR_B1};
            16'd4: ip_q = {b ^ XOR_B0, 24'h000000};
            16'd5: ip_q = ip_q | {8'h00, b ^ XOR_B1, 16'h0000};
            16'd6: ip_q = ip_q | {16'h0000, b ^ XOR_B2, 8'h00};
            16'd7: begin
              ip_q    = ip_q | {24'h000000, b ^ XOR_B3};
              found_q = 1'b1;
              phase_q = PH_DONE;
              return;
            end
            default: ;
          endcase
        end
        vpos_q = vpos_q + 16'd1;
        left_q = left_q - 16'd1;
        if (left_q == 0) begin
          vpos_q  = '0;
          phase_q = PH_ATTR_HDR;
        end
      end
      default: ;
    endcase
  endtask

  task automatic track_stun_byte(input smap_in_t item, output bit got, output smap_out_t rep);
    if (pos_q < OFF_LIMIT) begin
      parse_stun_byte(item.data_byte);
      pos_q = pos_q + 1'b1;
    end
    got = item.end_of_packet;
    rep = '0;
    if (got) begin
      if (!hdr_good || pos_q < OFF_MIN_HDR) begin
        rep.status = STS_NOT_BINDING;
      end else if (found_q) begin
        rep.status      = STS_FOUND;
        rep.mapped_ip   = ip_q;
        rep.mapped_port = port_q;
      end else begin
        rep.status = STS_NO_ATTR;
      end
      clear_parser();
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  always @(posedge clk) begin : check_reports
    smap_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          mismatches++;
        end
        if (out_data.mapped_ip !== want.mapped_ip) begin
          $display("%0t: mapped_ip expected %h actual %h", $time, want.mapped_ip,
                   out_data.mapped_ip);
          mismatches++;
        end
        if (out_data.mapped_port !== want.mapped_port) begin
          $display("%0t: mapped_port expected %h actual %h", $time, want.mapped_port,
                   out_data.mapped_port);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports outstanding", $time, pending_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eop);
    smap_in_t  item;
    smap_out_t want;
    bit        got;
    item.data_byte     = b;
    item.end_of_packet = eop;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_stun_byte(item, got, want);
    if (got) begin
      pending_reports.push_back(want);
      reports_made++;
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_datagram();
    for (int i = 0; i < datagram.size(); i++) begin
      send_byte(datagram[i], i == datagram.size() - 1);
    end
    datagram.delete();
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic add_filler(input int count);
    repeat (count) datagram.push_back(8'($urandom));
  endtask

  task automatic add_header();
    datagram.push_back(HDR_BYTE);
    datagram.push_back(HDR_BYTE);
    add_filler(18);
  endtask

  task automatic add_attr_head(input logic [15:0] kind, input logic [15:0] len);
    datagram.push_back(kind[15:8]);
    datagram.push_back(kind[7:0]);
    datagram.push_back(len[15:8]);
    datagram.push_back(len[7:0]);
  endtask

  task automatic add_attr(input logic [15:0] kind, input logic [15:0] len);
    add_attr_head(kind, len);
    add_filler((int'(len) + 3) & ~3);
  endtask

  task automatic add_mapped(input logic [31:0] ip, input logic [15:0] port);
    add_attr_head(ATTR_MAPPED, MIN_MAP_LEN);
    add_filler(2);
    datagram.push_back(port[15:8] ^ XOR_B0);
    datagram.push_back(port[7:0] ^ XOR_B1);
    datagram.push_back(ip[31:24] ^ XOR_B0);
    datagram.push_back(ip[23:16] ^ XOR_B1);
    datagram.push_back(ip[15:8] ^ XOR_B2);
    datagram.push_back(ip[7:0] ^ XOR_B3);
  endtask

  task automatic test_header_checks();
    datagram.push_back(HDR_BYTE);
    send_datagram();
    datagram.push_back(8'h00);
    send_datagram();
    datagram.push_back(HDR_BYTE);
    datagram.push_back(HDR_BYTE);
    send_datagram();
    add_header();
    datagram[1] = 8'hFF;
    send_datagram();
    add_header();
    send_datagram();
  endtask

  task automatic test_address_extremes();
    add_header();
    add_attr(16'hFFFF, 16'd0);
    add_attr(16'h0001, 16'd5);
    add_mapped(32'hFFFF_FFFF, 16'h0000);
    send_datagram();
    add_header();
    add_mapped(32'h0000_0000, 16'hFFFF);
    add_attr(16'h8028, 16'd4);
    send_datagram();
  endtask

  task automatic test_short_mapped_attr();
    add_header();
    add_attr(ATTR_MAPPED, 16'd4);
    add_mapped(32'($urandom), 16'($urandom));
    send_datagram();
    add_header();
    add_attr(ATTR_MAPPED, 16'd7);
    add_attr(16'h0006, 16'd3);
    send_datagram();
  endtask

  task automatic test_truncated_mapped();
    add_header();
    add_mapped(32'($urandom), 16'($urandom));
    repeat (3) void'(datagram.pop_back());
    send_datagram();
  endtask

  task automatic test_huge_length();
    add_header();
    add_attr_head(16'h0001, 16'hFFFF);
    add_filler(8);
    send_datagram();
    add_header();
    add_attr_head(ATTR_MAPPED, 16'hFFFD);
    add_filler(10);
    send_datagram();
  endtask

  task automatic test_byte_limit();
    // mapped value completes on the last parsed byte
    add_header();
    add_attr(16'h8022, 16'd988);
    add_mapped(32'($urandom), 16'($urandom));
    add_filler(20);
    send_datagram();
    // mapped value straddles the limit
    add_header();
    add_attr(16'h8022, 16'd992);
    add_mapped(32'($urandom), 16'($urandom));
    add_filler(4);
    send_datagram();
  endtask

  task automatic build_random_datagram();
    int         pick;
    int         cut;
    logic [7:0] bad;
    pick = $urandom_range(99);
    if (pick < 8) begin
      add_filler($urandom_range(1, 30));
    end else begin
      add_header();
      if (pick < 16) begin
        bad = 8'($urandom_range(255));
        if (bad == HDR_BYTE) bad = 8'h81;
        datagram[$urandom_range(1)] = bad;
      end
      repeat ($urandom_range(0, 2)) add_attr(16'($urandom), 16'($urandom_range(0, 12)));
      if ($urandom_range(3) == 0) add_attr(ATTR_MAPPED, 16'($urandom_range(0, 7)));
      if ($urandom_range(4) != 0) add_attr(ATTR_MAPPED, 16'($urandom_range(8, 12)));
      repeat ($urandom_range(0, 2)) add_attr(16'($urandom), 16'($urandom_range(0, 12)));
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(1, datagram.size());
        while (datagram.size() > cut) void'(datagram.pop_back());
      end
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input int byte_goal, input int report_goal);
    int bytes_start;
    int reports_start;
    wait_for_reports();
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    bytes_start   = bytes_sent;
    reports_start = reports_made;
    while (bytes_sent - bytes_start < byte_goal ||
           reports_made - reports_start < report_goal) begin
      build_random_datagram();
      send_datagram();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    src_idle_pct  = 6;
    snk_stall_pct = 71;
    bytes_sent    = 0;
    reports_made  = 0;
    mismatches    = 0;
    cycle_count   = 0;
    clear_parser();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_header_checks();
    test_address_extremes();
    test_short_mapped_attr();
    test_truncated_mapped();
    test_huge_length();
    test_byte_limit();
    test_random_traffic(6, 71, 250, 15);
    test_random_traffic(71, 6, 250, 15);
    test_random_traffic(0, 0, 250, 15);

    wait_for_reports();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
